// ===== hdl/tas_pkg.sv =====
// Shared types and constants for the tensor axis-swap address remapper.
// Used by every module under hdl/; depends on nothing else.
`default_nettype none

package tas_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_DIMS_DEF    = 8;
   localparam int EXTENT_BITS_DEF = 16;
   localparam int DATA_BITS_DEF   = 32;

   // Fixed field widths
   localparam int INDEX_BITS     = 32;
   localparam int SLOT_BITS      = 16;
   localparam int CFG_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int COUNT_BITS     = 4;
   localparam int AXIS_BITS      = 3;
   localparam int SAT_BITS       = INDEX_BITS + 1;
   localparam int RECIP_BITS     = INDEX_BITS + 1;
   localparam int QUO_STEP_BITS  = $clog2(RECIP_BITS);

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIM_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWAP_AXIS_A  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWAP_AXIS_B  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXTENTS_LOW  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXTENTS_HIGH = 3'd4;

   // Saturation point of element counts: 2^32
   localparam logic [SAT_BITS-1:0] TOTAL_CAP = {1'b1, {INDEX_BITS{1'b0}}};

   // Divisor slots, in the order the index is taken apart
   localparam int NUM_DIVS = 4;
   localparam int DIV_SEL_BITS = 2;
   localparam logic [DIV_SEL_BITS-1:0] DIV_Q    = 2'd0; // dims after the inner swap axis
   localparam logic [DIV_SEL_BITS-1:0] DIV_EB   = 2'd1; // extent of the inner swap axis
   localparam logic [DIV_SEL_BITS-1:0] DIV_M    = 2'd2; // dims between the swap axes
   localparam logic [DIV_SEL_BITS-1:0] DIV_EA   = 2'd3; // extent of the outer swap axis
   localparam logic [DIV_SEL_BITS-1:0] DIV_LAST = DIV_EA;

   // Back pipeline: three steps per division, then one multiply-add per divisor
   localparam int DIV_PHASES  = 3;
   localparam int BACK_STAGES = NUM_DIVS * DIV_PHASES + NUM_DIVS;

   localparam int QUEUE_DEPTH = 4;

   // One divisor: saturated value for division, low word for recombination,
   // and floor(2^32 / value) for the reciprocal multiply
   typedef struct packed {
      logic [SAT_BITS-1:0]   sat;
      logic [INDEX_BITS-1:0] wrap;
      logic [RECIP_BITS-1:0] recip;
   } divisor_type;

   // Shape summary handed from setup to the front and back
   typedef struct packed {
      logic                                axis_err;
      logic                                ident;
      logic [SAT_BITS-1:0]                 total;
      logic [NUM_DIVS-1:0][SAT_BITS+INDEX_BITS+RECIP_BITS-1:0] div_bits;
   } shape_type;

   // Classified item between front and back
   typedef struct packed {
      logic                  err;
      logic                  ident;
      logic [INDEX_BITS-1:0] idx;
   } item_type;

   // Word carried through the back pipeline
   typedef struct packed {
      logic                                err;
      logic                                ident;
      logic [INDEX_BITS-1:0]               orig;
      logic [INDEX_BITS-1:0]               x;
      logic [INDEX_BITS-1:0]               qe;
      logic [NUM_DIVS-1:0][INDEX_BITS-1:0] crd;
   } pipe_type;

endpackage

`default_nettype wire

// ===== hdl/tas_setup.sv =====
// Configuration registers and shape setup: element count, divisors and reciprocals.
// Depends on tas_pkg.
`default_nettype none

module tas_setup #(
   parameter int MAX_DIMS    = tas_pkg::MAX_DIMS_DEF,
   parameter int EXTENT_BITS = tas_pkg::EXTENT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tas_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tas_pkg::CFG_DATA_BITS-1:0]   csr_data,
   output logic                                     busy,
   output tas_pkg::shape_type                       shape
);

   localparam int DIM_BITS = $clog2(MAX_DIMS);
   localparam logic [DIM_BITS-1:0] DIM_LAST = DIM_BITS'(MAX_DIMS - 1);
   localparam logic [tas_pkg::QUO_STEP_BITS-1:0] STEP_TOP =
      tas_pkg::QUO_STEP_BITS'(tas_pkg::RECIP_BITS - 1);
   localparam logic [tas_pkg::SAT_BITS-1:0] SAT_ONE = tas_pkg::SAT_BITS'(1);
   localparam logic [tas_pkg::INDEX_BITS-1:0] WRAP_ONE = tas_pkg::INDEX_BITS'(1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROD  = 3'b010,
      ST_RECIP = 3'b100
   } setup_state_type;

   // Saturating product of a count and one extent
   function automatic logic [tas_pkg::SAT_BITS-1:0] sat_mul(
      input logic [tas_pkg::SAT_BITS-1:0]  a,
      input logic [tas_pkg::SLOT_BITS-1:0] e
   );
      logic [tas_pkg::SAT_BITS+tas_pkg::SLOT_BITS-1:0] p;
      p = (tas_pkg::SAT_BITS+tas_pkg::SLOT_BITS)'(a) *
          (tas_pkg::SAT_BITS+tas_pkg::SLOT_BITS)'(e);
      if (p > (tas_pkg::SAT_BITS+tas_pkg::SLOT_BITS)'(tas_pkg::TOTAL_CAP)) begin
         return tas_pkg::TOTAL_CAP;
      end
      return p[tas_pkg::SAT_BITS-1:0];
   endfunction

   // Product of a count and one extent, low word kept
   function automatic logic [tas_pkg::INDEX_BITS-1:0] wrap_mul(
      input logic [tas_pkg::INDEX_BITS-1:0] a,
      input logic [tas_pkg::SLOT_BITS-1:0]  e
   );
      logic [tas_pkg::INDEX_BITS+tas_pkg::SLOT_BITS-1:0] p;
      p = (tas_pkg::INDEX_BITS+tas_pkg::SLOT_BITS)'(a) *
          (tas_pkg::INDEX_BITS+tas_pkg::SLOT_BITS)'(e);
      return p[tas_pkg::INDEX_BITS-1:0];
   endfunction

   logic [tas_pkg::COUNT_BITS-1:0]    dim_count_ff, dim_count_in;
   logic [tas_pkg::AXIS_BITS-1:0]     axis_a_ff, axis_a_in;
   logic [tas_pkg::AXIS_BITS-1:0]     axis_b_ff, axis_b_in;
   logic [tas_pkg::CFG_DATA_BITS-1:0] ext_lo_ff, ext_lo_in;
   logic [tas_pkg::CFG_DATA_BITS-1:0] ext_hi_ff, ext_hi_in;

   setup_state_type                   state_ff, state_in;
   logic [DIM_BITS-1:0]               dim_ff, dim_in;
   logic [tas_pkg::SAT_BITS-1:0]      total_ff, total_in;
   tas_pkg::divisor_type [tas_pkg::NUM_DIVS-1:0] div_ff, div_in;
   logic [tas_pkg::DIV_SEL_BITS-1:0]  k_ff, k_in;
   logic [tas_pkg::QUO_STEP_BITS-1:0] step_ff, step_in;
   logic [tas_pkg::SAT_BITS-1:0]      rem_ff, rem_in;
   logic [tas_pkg::INDEX_BITS-1:0]    quo_ff, quo_in;

   logic [tas_pkg::COUNT_BITS-1:0]    n_eff;
   logic [tas_pkg::AXIS_BITS-1:0]     lo_axis, hi_axis;
   logic [tas_pkg::COUNT_BITS-1:0]    lo4, hi4, dim4;
   logic [tas_pkg::CFG_DATA_BITS-1:0] ext_word;
   logic [tas_pkg::SLOT_BITS-1:0]     ext_slot, ext_val;
   logic                              in_use;
   logic [tas_pkg::SAT_BITS:0]        shifted, trial;
   logic                              fits;

   assign csr_ready = 1'b1;

   // Clamp the dimension count and order the swap axes
   always_comb begin
      if (dim_count_ff == '0) begin
         n_eff = tas_pkg::COUNT_BITS'(1);
      end else if (dim_count_ff > tas_pkg::COUNT_BITS'(MAX_DIMS)) begin
         n_eff = tas_pkg::COUNT_BITS'(MAX_DIMS);
      end else begin
         n_eff = dim_count_ff;
      end
      lo_axis = (axis_a_ff < axis_b_ff) ? axis_a_ff : axis_b_ff;
      hi_axis = (axis_a_ff < axis_b_ff) ? axis_b_ff : axis_a_ff;
   end

   assign lo4  = {1'b0, lo_axis};
   assign hi4  = {1'b0, hi_axis};
   assign dim4 = tas_pkg::COUNT_BITS'(dim_ff);

   // Pick the extent of the dimension under the sweep
   assign ext_word = (dim4 < tas_pkg::COUNT_BITS'(4)) ? ext_lo_ff : ext_hi_ff;
   assign ext_slot = ext_word[{dim4[1:0], 4'b0000} +: tas_pkg::SLOT_BITS];
   assign ext_val  = tas_pkg::SLOT_BITS'(ext_slot[EXTENT_BITS-1:0]);
   assign in_use   = dim4 < n_eff;

   // Restoring division step for the reciprocal: 2^32 / divisor, one bit a cycle
   assign shifted = {rem_ff, (step_ff == STEP_TOP)};
   assign fits    = shifted >= {1'b0, div_ff[k_ff].sat};
   assign trial   = shifted - {1'b0, div_ff[k_ff].sat};

   always_comb begin
      dim_count_in = dim_count_ff;
      axis_a_in    = axis_a_ff;
      axis_b_in    = axis_b_ff;
      ext_lo_in    = ext_lo_ff;
      ext_hi_in    = ext_hi_ff;
      state_in     = state_ff;
      dim_in       = dim_ff;
      total_in     = total_ff;
      div_in       = div_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;

      case (state_ff)
         ST_PROD: begin
            // accumulate products over one dimension
            if (in_use) begin
               total_in = sat_mul(total_ff, ext_val);
            end
            if (in_use && (dim4 > hi4)) begin
               div_in[tas_pkg::DIV_Q].sat  = sat_mul(div_ff[tas_pkg::DIV_Q].sat, ext_val);
               div_in[tas_pkg::DIV_Q].wrap = wrap_mul(div_ff[tas_pkg::DIV_Q].wrap, ext_val);
            end
            if (in_use && (dim4 > lo4) && (dim4 < hi4)) begin
               div_in[tas_pkg::DIV_M].sat  = sat_mul(div_ff[tas_pkg::DIV_M].sat, ext_val);
               div_in[tas_pkg::DIV_M].wrap = wrap_mul(div_ff[tas_pkg::DIV_M].wrap, ext_val);
            end
            if (dim4 == hi4) begin
               div_in[tas_pkg::DIV_EB].sat  = tas_pkg::SAT_BITS'(ext_val);
               div_in[tas_pkg::DIV_EB].wrap = tas_pkg::INDEX_BITS'(ext_val);
            end
            if (dim4 == lo4) begin
               div_in[tas_pkg::DIV_EA].sat  = tas_pkg::SAT_BITS'(ext_val);
               div_in[tas_pkg::DIV_EA].wrap = tas_pkg::INDEX_BITS'(ext_val);
            end
            if (dim_ff == DIM_LAST) begin
               state_in = ST_RECIP;
               k_in     = '0;
               step_in  = STEP_TOP;
               rem_in   = '0;
               quo_in   = '0;
            end else begin
               dim_in = dim_ff + DIM_BITS'(1);
            end
         end
         ST_RECIP: begin
            // shift in one quotient bit; store the reciprocal after the last one
            rem_in = fits ? trial[tas_pkg::SAT_BITS-1:0] : shifted[tas_pkg::SAT_BITS-1:0];
            quo_in = {quo_ff[tas_pkg::INDEX_BITS-2:0], fits};
            if (step_ff == '0) begin
               div_in[k_ff].recip = {quo_ff, fits};
               step_in = STEP_TOP;
               rem_in  = '0;
               quo_in  = '0;
               if (k_ff == tas_pkg::DIV_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + tas_pkg::DIV_SEL_BITS'(1);
               end
            end else begin
               step_in = step_ff - tas_pkg::QUO_STEP_BITS'(1);
            end
         end
         ST_IDLE: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write: update and restart the setup sweep
      if (csr_valid) begin
         case (csr_index)
            tas_pkg::CSR_DIM_COUNT:    dim_count_in = csr_data[tas_pkg::COUNT_BITS-1:0];
            tas_pkg::CSR_SWAP_AXIS_A:  axis_a_in    = csr_data[tas_pkg::AXIS_BITS-1:0];
            tas_pkg::CSR_SWAP_AXIS_B:  axis_b_in    = csr_data[tas_pkg::AXIS_BITS-1:0];
            tas_pkg::CSR_EXTENTS_LOW:  ext_lo_in    = csr_data;
            tas_pkg::CSR_EXTENTS_HIGH: ext_hi_in    = csr_data;
            default: begin
            end
         endcase
         state_in = ST_PROD;
         dim_in   = '0;
         total_in = SAT_ONE;
         for (int i = 0; i < tas_pkg::NUM_DIVS; i++) begin
            div_in[i].sat  = SAT_ONE;
            div_in[i].wrap = WRAP_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= tas_pkg::COUNT_BITS'(1);
         axis_a_ff    <= '0;
         axis_b_ff    <= '0;
         ext_lo_ff    <= tas_pkg::CFG_DATA_BITS'(1);
         ext_hi_ff    <= '0;
         state_ff     <= ST_PROD;
         dim_ff       <= '0;
         total_ff     <= SAT_ONE;
         k_ff         <= '0;
         step_ff      <= STEP_TOP;
         rem_ff       <= '0;
         quo_ff       <= '0;
         for (int i = 0; i < tas_pkg::NUM_DIVS; i++) begin
            div_ff[i].sat   <= SAT_ONE;
            div_ff[i].wrap  <= WRAP_ONE;
            div_ff[i].recip <= '0;
         end
      end else begin
         dim_count_ff <= dim_count_in;
         axis_a_ff    <= axis_a_in;
         axis_b_ff    <= axis_b_in;
         ext_lo_ff    <= ext_lo_in;
         ext_hi_ff    <= ext_hi_in;
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         total_ff     <= total_in;
         div_ff       <= div_in;
         k_ff         <= k_in;
         step_ff      <= step_in;
         rem_ff       <= rem_in;
         quo_ff       <= quo_in;
      end
   end

   // Shape summary
   assign busy           = (state_ff != ST_IDLE);
   assign shape.axis_err = ({1'b0, axis_a_ff} >= n_eff) || ({1'b0, axis_b_ff} >= n_eff);
   assign shape.ident    = (axis_a_ff == axis_b_ff);
   assign shape.total    = total_ff;
   assign shape.div_bits = div_ff;

endmodule

`default_nettype wire

// ===== hdl/tas_front.sv =====
// Front end: accepts request words and flags range errors and identity swaps.
// Depends on tas_pkg; feeds tas_queue.
`default_nettype none

module tas_front #(
   parameter int DATA_BITS = tas_pkg::DATA_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tas_pkg::INDEX_BITS-1:0]  req_element_index,
   input  wire logic [DATA_BITS-1:0]            req_element_value,
   input  wire logic                            setup_busy,
   input  wire tas_pkg::shape_type              shape,
   input  wire logic                            q_full,
   output logic                                 push,
   output tas_pkg::item_type                    push_item,
   output logic [DATA_BITS-1:0]                 push_value
);

   logic                 vld_ff, vld_in;
   tas_pkg::item_type    item_ff, item_in;
   logic [DATA_BITS-1:0] value_ff;
   logic                 accept;

   // Hand the held word to the queue whenever it has room
   assign push      = vld_ff && !q_full;
   assign req_ready = !setup_busy && (!vld_ff || !q_full);
   assign accept    = req_valid && req_ready;

   // Classify the incoming word
   always_comb begin
      item_in.idx   = req_element_index;
      item_in.ident = shape.ident;
      item_in.err   = shape.axis_err ||
                      ({1'b0, req_element_index} >= shape.total);
   end

   assign vld_in = accept ? 1'b1 : (push ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff  <= item_in;
         value_ff <= req_element_value;
      end
   end

   assign push_item  = item_ff;
   assign push_value = value_ff;

endmodule

`default_nettype wire

// ===== hdl/tas_queue.sv =====
// Short queue between the front and the back of the remapper.
// Depends on tas_pkg for the default depth.
`default_nettype none

module tas_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = tas_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      head
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == CNT_BITS'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tas_back.sv =====
// Back end: splits the index by four divisors, swaps, recombines, holds the response.
// Depends on tas_pkg; reads words from tas_queue.
`default_nettype none

module tas_back #(
   parameter int DATA_BITS = tas_pkg::DATA_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_empty,
   input  wire tas_pkg::item_type               q_item,
   input  wire logic [DATA_BITS-1:0]            q_value,
   output logic                                 pop,
   input  wire tas_pkg::shape_type              shape,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tas_pkg::INDEX_BITS-1:0]       rsp_target_index,
   output logic [DATA_BITS-1:0]                 rsp_target_value,
   output logic                                 rsp_range_error
);

   localparam int NS = tas_pkg::BACK_STAGES;
   localparam int IW = tas_pkg::INDEX_BITS;

   tas_pkg::divisor_type [tas_pkg::NUM_DIVS-1:0] div;

   logic                 vld_ff [NS];
   tas_pkg::pipe_type    st_ff  [NS];
   logic [DATA_BITS-1:0] val_ff [NS];
   tas_pkg::pipe_type    nxt    [NS];
   tas_pkg::pipe_type    head_word;

   logic                 out_vld_ff;
   logic [IW-1:0]        out_index_ff, out_index_in;
   logic [DATA_BITS-1:0] out_value_ff;
   logic                 out_err_ff;
   logic                 adv;

   assign div = shape.div_bits;

   // Move the whole pipe when the response slot frees up
   assign adv = !out_vld_ff || rsp_ready;
   assign pop = adv && !q_empty;

   always_comb begin
      head_word       = '0;
      head_word.err   = q_item.err;
      head_word.ident = q_item.ident;
      head_word.orig  = q_item.idx;
      head_word.x     = q_item.idx;
   end

   // Division by divisor k: reciprocal estimate, remainder, one correction
   for (genvar k = 0; k < tas_pkg::NUM_DIVS; k++) begin : g_div
      localparam int S0 = k * tas_pkg::DIV_PHASES;
      logic [2*IW:0]   est_prod;
      logic [2*IW-1:0] back_prod;

      always_comb begin
         est_prod = (2*IW+1)'(st_ff[S0].x) * (2*IW+1)'(div[k].recip);
         nxt[S0]    = st_ff[S0];
         nxt[S0].qe = est_prod[2*IW-1:IW];
      end

      always_comb begin
         back_prod = (2*IW)'(st_ff[S0+1].qe) * (2*IW)'(div[k].wrap);
         nxt[S0+1]        = st_ff[S0+1];
         nxt[S0+1].crd[k] = st_ff[S0+1].x - back_prod[IW-1:0];
      end

      always_comb begin
         nxt[S0+2] = st_ff[S0+2];
         if ({1'b0, st_ff[S0+2].crd[k]} >= div[k].sat) begin
            nxt[S0+2].x      = st_ff[S0+2].qe + IW'(1);
            nxt[S0+2].crd[k] = st_ff[S0+2].crd[k] - div[k].wrap;
         end else begin
            nxt[S0+2].x = st_ff[S0+2].qe;
         end
      end
   end

   // Recombine against the swapped shape, outermost first
   for (genvar j = 0; j < tas_pkg::NUM_DIVS; j++) begin : g_mac
      localparam int S = tas_pkg::NUM_DIVS * tas_pkg::DIV_PHASES + j;
      localparam int K = (j + 1) % tas_pkg::NUM_DIVS;
      logic [2*IW-1:0] mac;

      always_comb begin
         mac = (2*IW)'(st_ff[S].x) * (2*IW)'(div[K].wrap);
         nxt[S]   = st_ff[S];
         nxt[S].x = mac[IW-1:0] + st_ff[S].crd[K];
      end
   end

   // Pick the response index
   always_comb begin
      if (nxt[NS-1].err) begin
         out_index_in = '0;
      end else if (nxt[NS-1].ident) begin
         out_index_in = nxt[NS-1].orig;
      end else begin
         out_index_in = nxt[NS-1].x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= !q_empty;
         for (int s = 1; s < NS; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         out_vld_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0]  <= head_word;
         val_ff[0] <= q_value;
         for (int s = 1; s < NS; s++) begin
            st_ff[s]  <= nxt[s-1];
            val_ff[s] <= val_ff[s-1];
         end
         out_index_ff <= out_index_in;
         out_value_ff <= val_ff[NS-1];
         out_err_ff   <= nxt[NS-1].err;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_target_index = out_index_ff;
   assign rsp_target_value = out_value_ff;
   assign rsp_range_error  = out_err_ff;

endmodule

`default_nettype wire

// ===== hdl/tensor_axis_swap_address.sv =====
// Top level of the tensor axis-swap address remapper.
// Depends on tas_pkg, tas_setup, tas_front, tas_queue and tas_back.
`default_nettype none

// Maps a row-major element index to its index in the tensor with two axes
// exchanged, passing the data word through. One word is taken per cycle
// while the shape setup is idle and the queue has room; each word passes
// the front register, the queue, sixteen back stages (four divisions by
// reciprocal multiply of three steps each and four multiply-adds), then the
// response register. After reset and after every csr write, req_ready stays
// low while the block forms the element count and divisors one dimension at
// a time, then runs each divisor through the shared bit-serial reciprocal
// divider. Indexes at or beyond the element count and swap axes at or
// beyond the dimension count return range_error with a zero target index.
module tensor_axis_swap_address #(
   parameter int MAX_DIMS    = tas_pkg::MAX_DIMS_DEF,
   parameter int EXTENT_BITS = tas_pkg::EXTENT_BITS_DEF,
   parameter int DATA_BITS   = tas_pkg::DATA_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tas_pkg::INDEX_BITS-1:0]      req_element_index,
   input  wire logic [DATA_BITS-1:0]                req_element_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [tas_pkg::INDEX_BITS-1:0]           rsp_target_index,
   output logic [DATA_BITS-1:0]                     rsp_target_value,
   output logic                                     rsp_range_error,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tas_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tas_pkg::CFG_DATA_BITS-1:0]   csr_data
);

   localparam int ITEM_BITS = $bits(tas_pkg::item_type);
   localparam int Q_WIDTH   = ITEM_BITS + DATA_BITS;

   logic                 setup_busy;
   tas_pkg::shape_type   shape;
   logic                 q_full, q_empty, q_push, q_pop;
   tas_pkg::item_type    push_item, q_item;
   logic [DATA_BITS-1:0] push_value, q_value;
   logic [Q_WIDTH-1:0]   q_head;

   tas_setup #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (setup_busy),
      .shape     (shape)
   );

   tas_front #(
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .setup_busy        (setup_busy),
      .shape             (shape),
      .q_full            (q_full),
      .push              (q_push),
      .push_item         (push_item),
      .push_value        (push_value)
   );

   tas_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (tas_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_item, push_value}),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Split the queue word back into its fields
   assign q_item  = tas_pkg::item_type'(q_head[Q_WIDTH-1 -: ITEM_BITS]);
   assign q_value = q_head[DATA_BITS-1:0];

   tas_back #(
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_item           (q_item),
      .q_value          (q_value),
      .pop              (q_pop),
      .shape            (shape),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_target_index (rsp_target_index),
      .rsp_target_value (rsp_target_value),
      .rsp_range_error  (rsp_range_error)
   );

   // No request is taken while the shape setup runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !setup_busy)
      else $error("request accepted during shape setup");

   // A register write stalls the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("request side open right after a register write");

   // An error response carries a zero index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> (rsp_target_index == '0))
      else $error("error response with nonzero target index");

endmodule

`default_nettype wire
